### hdl/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg: shared types and constants for the spring force block
// Holds default parameter values, register widths, reset values and the
// configuration register index codes.
// ----------------------------------------------------------------------------
package sbf_pkg;

  // Default pipeline parameters.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Configuration register widths.
  localparam int K_W        = 32;
  localparam int REST_W     = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register index codes.
  localparam cfg_idx_t CFG_SPRING_CONSTANT = 2'd0;
  localparam cfg_idx_t CFG_REST_LENGTH     = 2'd1;
  localparam cfg_idx_t CFG_CORD_MODE       = 2'd2;

  // Cord mode codes.
  localparam logic MODE_SPRING = 1'b0;
  localparam logic MODE_BUNGEE = 1'b1;

  // Reset values.
  localparam logic [K_W-1:0]    K_RESET    = 32'd65536;
  localparam logic [REST_W-1:0] REST_RESET = 31'd65536;

  // Per-item status that rides alongside the arithmetic.
  typedef struct packed {
    logic zero;   // separation has zero length
    logic slack;  // bungee is not stretched
  } flags_t;

endpackage

### hdl/sbf_if.sv
// ----------------------------------------------------------------------------
// sbf_if: item channels of the spring force block
// Valid/ready channels carrying one position pair in and one force out.
// ----------------------------------------------------------------------------
interface sbf_in_if #(
  parameter int COORD_WIDTH = sbf_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] self_x;
  logic signed [COORD_WIDTH-1:0] self_y;
  logic signed [COORD_WIDTH-1:0] self_z;
  logic signed [COORD_WIDTH-1:0] partner_x;
  logic signed [COORD_WIDTH-1:0] partner_y;
  logic signed [COORD_WIDTH-1:0] partner_z;

  modport source (
    output valid, self_x, self_y, self_z, partner_x, partner_y, partner_z,
    input  ready
  );
  modport sink (
    input  valid, self_x, self_y, self_z, partner_x, partner_y, partner_z,
    output ready
  );
endinterface

interface sbf_out_if #(
  parameter int COORD_WIDTH = sbf_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] force_x;
  logic signed [COORD_WIDTH-1:0] force_y;
  logic signed [COORD_WIDTH-1:0] force_z;
  logic                          force_applied;
  logic                          saturated;

  modport source (
    output valid, force_x, force_y, force_z, force_applied, saturated,
    input  ready
  );
  modport sink (
    input  valid, force_x, force_y, force_z, force_applied, saturated,
    output ready
  );
endinterface

### hdl/sbf_delay.sv
// ----------------------------------------------------------------------------
// sbf_delay: stallable delay line
// Carries side data alongside the arithmetic pipeline for a fixed depth.
// ----------------------------------------------------------------------------
module sbf_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  // Shift the line whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= din;
      for (int s = 1; s < DEPTH; s++) begin
        tap_r[s] <= tap_r[s-1];
      end
    end
  end

  assign dout = tap_r[DEPTH-1];

endmodule

### hdl/sbf_mul.sv
// ----------------------------------------------------------------------------
// sbf_mul: two-stage unsigned multiplier
// Splits each operand in halves, registers the four partial products, then
// registers their aligned sum.
// ----------------------------------------------------------------------------
module sbf_mul #(
  parameter int A_W = 33,
  parameter int B_W = 33
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int AL = A_W / 2;
  localparam int AH = A_W - AL;
  localparam int BL = B_W / 2;
  localparam int BH = B_W - BL;
  localparam int PW = A_W + B_W;

  logic [AL+BL-1:0] ll_r, ll_nxt;
  logic [AL+BH-1:0] lh_r, lh_nxt;
  logic [AH+BL-1:0] hl_r, hl_nxt;
  logic [AH+BH-1:0] hh_r, hh_nxt;
  logic [PW-1:0]    p_r, p_nxt;

  // Partial products of the operand halves.
  always_comb begin
    ll_nxt = (AL+BL)'(a[AL-1:0])   * (AL+BL)'(b[BL-1:0]);
    lh_nxt = (AL+BH)'(a[AL-1:0])   * (AL+BH)'(b[B_W-1:BL]);
    hl_nxt = (AH+BL)'(a[A_W-1:AL]) * (AH+BL)'(b[BL-1:0]);
    hh_nxt = (AH+BH)'(a[A_W-1:AL]) * (AH+BH)'(b[B_W-1:BL]);
  end

  // Aligned sum of the partial products.
  always_comb begin
    p_nxt = (PW'(hh_r) << (AL + BL)) + (PW'(hl_r) << AL) + (PW'(lh_r) << BL) + PW'(ll_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt;
      hl_r <= hl_nxt;
      hh_r <= hh_nxt;
      p_r  <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

### hdl/sbf_isqrt.sv
// ----------------------------------------------------------------------------
// sbf_isqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per register stage.
// ----------------------------------------------------------------------------
module sbf_isqrt #(
  parameter int IN_W = 68
) (
  input  logic                clk,
  input  logic                en,
  input  logic [IN_W-1:0]     radicand,
  output logic [IN_W/2-1:0]   root
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;

  logic [REM_W-1:0] rem_r  [OUT_W];
  logic [REM_W-1:0] rem_nxt [OUT_W];
  logic [OUT_W-1:0] root_r [OUT_W];
  logic [OUT_W-1:0] root_nxt [OUT_W];
  logic [IN_W-1:0]  rad_r  [OUT_W];
  logic [IN_W-1:0]  rad_nxt [OUT_W];

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [OUT_W-1:0] root_in;
    logic [IN_W-1:0]  rad_in;
    for (int s = 0; s < OUT_W; s++) begin
      if (s == 0) begin
        rem_in  = '0;
        root_in = '0;
        rad_in  = radicand;
      end else begin
        rem_in  = rem_r[s-1];
        root_in = root_r[s-1];
        rad_in  = rad_r[s-1];
      end
      rem_sh = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
      trial  = {root_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt[s]  = rem_sh - trial;
        root_nxt[s] = {root_in[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt[s]  = rem_sh;
        root_nxt[s] = {root_in[OUT_W-2:0], 1'b0};
      end
      rad_nxt[s] = rad_in << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < OUT_W; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        rad_r[s]  <= rad_nxt[s];
      end
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

### hdl/sbf_div.sv
// ----------------------------------------------------------------------------
// sbf_div: pipelined restoring divider with range check
// Produces Q_W quotient bits, one per stage, after a stage that flags
// quotients too large for Q_W bits.
// ----------------------------------------------------------------------------
module sbf_div #(
  parameter int N_W = 83,
  parameter int D_W = 34,
  parameter int Q_W = 33
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] n,
  input  logic [D_W-1:0] d,
  output logic [Q_W-1:0] q,
  output logic           ovf
);

  localparam int CW = (N_W > D_W) ? N_W : D_W;

  // Range check stage.
  logic [D_W-1:0] rem0_r, rem0_nxt;
  logic [Q_W-1:0] lo0_r, lo0_nxt;
  logic [D_W-1:0] d0_r;
  logic           ovf0_r, ovf0_nxt;

  // Quotient stages.
  logic [D_W-1:0] rem_r  [Q_W];
  logic [D_W-1:0] rem_nxt [Q_W];
  logic [Q_W-1:0] q_r    [Q_W];
  logic [Q_W-1:0] q_nxt  [Q_W];
  logic [Q_W-1:0] lo_r   [Q_W];
  logic [Q_W-1:0] lo_nxt [Q_W];
  logic [D_W-1:0] d_r    [Q_W];
  logic           ovf_r  [Q_W];

  // The quotient fits in Q_W bits only if the high dividend part is below d.
  always_comb begin
    ovf0_nxt = CW'(n >> Q_W) >= CW'(d);
    rem0_nxt = D_W'(n >> Q_W);
    lo0_nxt  = n[Q_W-1:0];
  end

  // Shift in one dividend bit, subtract the divisor where it fits.
  always_comb begin
    logic [D_W-1:0] rem_in;
    logic [D_W:0]   rem_sh;
    logic [Q_W-1:0] q_in;
    logic [Q_W-1:0] lo_in;
    logic [D_W-1:0] d_in;
    for (int s = 0; s < Q_W; s++) begin
      if (s == 0) begin
        rem_in = rem0_r;
        q_in   = '0;
        lo_in  = lo0_r;
        d_in   = d0_r;
      end else begin
        rem_in = rem_r[s-1];
        q_in   = q_r[s-1];
        lo_in  = lo_r[s-1];
        d_in   = d_r[s-1];
      end
      rem_sh = {rem_in, lo_in[Q_W-1]};
      if (rem_sh >= (D_W+1)'(d_in)) begin
        rem_nxt[s] = D_W'(rem_sh - (D_W+1)'(d_in));
        q_nxt[s]   = {q_in[Q_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = D_W'(rem_sh);
        q_nxt[s]   = {q_in[Q_W-2:0], 1'b0};
      end
      lo_nxt[s] = lo_in << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0_r <= rem0_nxt;
      lo0_r  <= lo0_nxt;
      d0_r   <= d;
      ovf0_r <= ovf0_nxt;
      for (int s = 0; s < Q_W; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        lo_r[s]  <= lo_nxt[s];
        d_r[s]   <= (s == 0) ? d0_r : d_r[s-1];
        ovf_r[s] <= (s == 0) ? ovf0_r : ovf_r[s-1];
      end
    end
  end

  assign q   = q_r[Q_W-1];
  assign ovf = ovf_r[Q_W-1];

endmodule

### hdl/spring_bungee_force.sv
// ----------------------------------------------------------------------------
// spring_bungee_force: 3-D Hooke spring / bungee force, pipelined
//
// in_ch carries one item: the particle position and its partner position,
// signed fixed point. out_ch returns one item per input: the three force
// components, saturated, plus force_applied and saturated flags. Both are
// valid/ready channels; an item moves when valid and ready are both high.
// cfg_we/cfg_idx/cfg_data write the spring constant, rest length and cord
// mode; write them only while no item is in flight.
//
// One item is accepted every cycle unless a finished result waits on the
// receiver. The square root and the divider each resolve one result bit
// per stage.
// Reset clears all valid bits and loads the register defaults. While the
// receiver holds ready low with a result waiting, the whole pipeline holds
// and in_ch.ready drops; nothing moves until the waiting result is taken.
// ----------------------------------------------------------------------------
module spring_bungee_force #(
  parameter int COORD_WIDTH = sbf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = sbf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  sbf_pkg::cfg_idx_t               cfg_idx,
  input  logic [sbf_pkg::CFG_DATA_W-1:0]  cfg_data,
  sbf_in_if.sink                          in_ch,
  sbf_out_if.source                       out_ch
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int MAG_W  = W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W + 2;
  localparam int LEN_W  = SUM_W / 2;
  localparam int K_W    = sbf_pkg::K_W;
  localparam int REST_W = sbf_pkg::REST_W;
  localparam int DIFF_W = (LEN_W > REST_W) ? LEN_W : REST_W;
  localparam int KD_W   = K_W + DIFF_W;
  localparam int M_W    = KD_W - F;
  localparam int N_W    = M_W + MAG_W;
  localparam int Q_W    = W + 1;
  localparam int L_MUL  = 2;
  localparam int L_DIV  = Q_W + 1;
  localparam int DLY_MAG = L_MUL + 1 + LEN_W + 1 + L_MUL;
  localparam int DLY_LEN = 2 * L_MUL;
  localparam int DLY_NEG = L_MUL + L_DIV;
  localparam int DLY_FLG = 2 * L_MUL + L_DIV;
  localparam int FLG_W   = $bits(sbf_pkg::flags_t);
  localparam int LAT     = 2 + L_MUL + 1 + LEN_W + 1 + 2 * L_MUL + L_DIV + 1;

  // Configuration registers.
  logic [K_W-1:0]    k_r, k_nxt;
  logic [REST_W-1:0] rest_r, rest_nxt;
  logic              mode_r, mode_nxt;

  // Pipeline control.
  logic           en;
  logic [LAT-1:0] vld_r, vld_nxt;

  // Arithmetic path.
  logic [W-1:0]      self_a [3];
  logic [W-1:0]      part_a [3];
  logic [MAG_W-1:0]  d_r [3];
  logic [MAG_W-1:0]  mag_r [3];
  logic              neg_r [3];
  logic [SQ_W-1:0]   sq [3];
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_r;
  logic [DIFF_W-1:0] diff_r, diff_nxt;
  sbf_pkg::flags_t   flg_r, flg_nxt;
  logic [KD_W-1:0]   kd;
  logic [M_W-1:0]    m_val;
  logic [MAG_W:0]    magd [3];
  logic [N_W-1:0]    prod [3];
  logic [LEN_W-1:0]  lend;
  logic [Q_W-1:0]    quo [3];
  logic              ovf [3];
  logic              negd [3];
  logic [FLG_W-1:0]  flgd_v;
  sbf_pkg::flags_t   flgd;

  // Output register.
  logic [W-1:0] frc_r [3];
  logic [W-1:0] frc_nxt [3];
  logic         app_r, app_nxt;
  logic         sat_r, sat_nxt;

  // Register write decode.
  always_comb begin
    k_nxt    = k_r;
    rest_nxt = rest_r;
    mode_nxt = mode_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        sbf_pkg::CFG_SPRING_CONSTANT: k_nxt    = cfg_data[K_W-1:0];
        sbf_pkg::CFG_REST_LENGTH:     rest_nxt = cfg_data[REST_W-1:0];
        sbf_pkg::CFG_CORD_MODE:       mode_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= sbf_pkg::K_RESET;
      rest_r <= sbf_pkg::REST_RESET;
      mode_r <= sbf_pkg::MODE_SPRING;
    end else begin
      k_r    <= k_nxt;
      rest_r <= rest_nxt;
      mode_r <= mode_nxt;
    end
  end

  // The pipeline advances unless a finished item waits on the receiver.
  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;
  assign vld_nxt     = {vld_r[LAT-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign self_a[0] = in_ch.self_x;
  assign self_a[1] = in_ch.self_y;
  assign self_a[2] = in_ch.self_z;
  assign part_a[0] = in_ch.partner_x;
  assign part_a[1] = in_ch.partner_y;
  assign part_a[2] = in_ch.partner_z;

  // Separation, then its magnitude and sign.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= {self_a[i][W-1], self_a[i]} - {part_a[i][W-1], part_a[i]};
        neg_r[i] <= d_r[i][MAG_W-1];
        mag_r[i] <= d_r[i][MAG_W-1] ? (MAG_W'(0) - d_r[i]) : d_r[i];
      end
    end
  end

  // Sum of squares.
  assign sum_nxt = SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= sum_nxt;
    end
  end

  sbf_isqrt #(.IN_W(SUM_W)) u_isqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum_r),
    .root     (len)
  );

  // Stretch against rest length, plus the no-force cases.
  always_comb begin
    logic [DIFF_W-1:0] len_e;
    logic [DIFF_W-1:0] rest_e;
    len_e  = DIFF_W'(len);
    rest_e = DIFF_W'(rest_r);
    diff_nxt      = (len_e >= rest_e) ? (len_e - rest_e) : (rest_e - len_e);
    flg_nxt.zero  = (len == '0);
    flg_nxt.slack = (mode_r == sbf_pkg::MODE_BUNGEE) && !(len_e > rest_e);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r <= diff_nxt;
      flg_r  <= flg_nxt;
      len_r  <= len;
    end
  end

  sbf_mul #(.A_W(K_W), .B_W(DIFF_W)) u_kd (
    .clk (clk),
    .en  (en),
    .a   (k_r),
    .b   (diff_r),
    .p   (kd)
  );

  assign m_val = kd[KD_W-1:F];

  sbf_delay #(.WIDTH(LEN_W), .DEPTH(DLY_LEN)) u_dlen (
    .clk  (clk),
    .en   (en),
    .din  (len_r),
    .dout (lend)
  );

  sbf_delay #(.WIDTH(FLG_W), .DEPTH(DLY_FLG)) u_dflg (
    .clk  (clk),
    .en   (en),
    .din  (flg_r),
    .dout (flgd_v)
  );

  assign flgd = flgd_v;

  // Per-axis square, scale and divide.
  for (genvar gi = 0; gi < 3; gi++) begin : g_axis
    sbf_mul #(.A_W(MAG_W), .B_W(MAG_W)) u_sq (
      .clk (clk),
      .en  (en),
      .a   (mag_r[gi]),
      .b   (mag_r[gi]),
      .p   (sq[gi])
    );

    sbf_delay #(.WIDTH(MAG_W+1), .DEPTH(DLY_MAG)) u_dmag (
      .clk  (clk),
      .en   (en),
      .din  ({neg_r[gi], mag_r[gi]}),
      .dout (magd[gi])
    );

    sbf_mul #(.A_W(M_W), .B_W(MAG_W)) u_mm (
      .clk (clk),
      .en  (en),
      .a   (m_val),
      .b   (magd[gi][MAG_W-1:0]),
      .p   (prod[gi])
    );

    sbf_delay #(.WIDTH(1), .DEPTH(DLY_NEG)) u_dneg (
      .clk  (clk),
      .en   (en),
      .din  (magd[gi][MAG_W]),
      .dout (negd[gi])
    );

    sbf_div #(.N_W(N_W), .D_W(LEN_W), .Q_W(Q_W)) u_div (
      .clk (clk),
      .en  (en),
      .n   (prod[gi]),
      .d   (lend),
      .q   (quo[gi]),
      .ovf (ovf[gi])
    );
  end

  // Sign and saturation; the force opposes the separation.
  always_comb begin
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] negq;
    logic [W-1:0]   min_v;
    logic           clip;
    lim     = Q_W'(1) << (W - 1);
    min_v   = W'(1) << (W - 1);
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      negq = ~quo[i] + Q_W'(1);
      if (negd[i]) begin
        clip       = ovf[i] || (quo[i] >= lim);
        frc_nxt[i] = clip ? ~min_v : quo[i][W-1:0];
      end else begin
        clip       = ovf[i] || (quo[i] > lim);
        frc_nxt[i] = clip ? min_v : negq[W-1:0];
      end
      sat_nxt = sat_nxt | clip;
    end
    app_nxt = 1'b1;
    if (flgd.zero || flgd.slack) begin
      for (int i = 0; i < 3; i++) begin
        frc_nxt[i] = '0;
      end
      sat_nxt = 1'b0;
      app_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        frc_r[i] <= frc_nxt[i];
      end
      app_r <= app_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid         = vld_r[LAT-1];
  assign out_ch.force_x       = frc_r[0];
  assign out_ch.force_y       = frc_r[1];
  assign out_ch.force_z       = frc_r[2];
  assign out_ch.force_applied = app_r;
  assign out_ch.saturated     = sat_r;

  // A stall freezes every valid bit in place.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(!en) |-> vld_r == $past(vld_r))
    else $error("valid bits moved during a stall");

  // An advancing pipeline moves each item one stage.
  a_shift: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(en) |-> vld_r[LAT-1] == $past(vld_r[LAT-2]))
    else $error("item lost or repeated in the pipeline");

  // Without an applied force every component is zero and nothing clips.
  a_no_force: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.force_applied |->
      out_ch.force_x == '0 && out_ch.force_y == '0 && out_ch.force_z == '0 &&
      !out_ch.saturated)
    else $error("nonzero force without force_applied");

  // Clipping is reported only for an applied force.
  a_sat_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.saturated |-> out_ch.force_applied)
    else $error("saturated without an applied force");

endmodule
